[design/udrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udrb_pkg
// Shared types and codes for the UART dual ring buffer.
// ----------------------------------------------------------------------------
package udrb_pkg;

  // Item command codes
  typedef enum logic [1:0] {
    CMD_SERVICE = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic       rx_complete;
    logic       tx_empty;
    logic [7:0] data_byte;
    logic       batch_last;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [7:0] rx_available;
    logic       rx_overflow;
    logic       tx_irq_armed;
    logic       write_accepted;
  } out_item_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic exec;
  } ctrl_cmd_t;

  localparam logic [7:0] AvailMax = 8'hFF;

endpackage

[design/udrb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udrb_ctrl
// Handshake controller: accepts items and holds the result until taken.
// ----------------------------------------------------------------------------
module udrb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output udrb_pkg::ctrl_cmd_t   cmd_o
);
  import udrb_pkg::*;

  state_e state_q, state_d;
  logic   exec;

  assign exec = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (exec) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready_i) state_d = exec ? ST_RESP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_RESP: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;  // next item enters as the result leaves
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign cmd_o.exec = exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/udrb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udrb_datapath
// Receive and transmit rings: storage, pointers, flags and result fields.
// ----------------------------------------------------------------------------
module udrb_datapath #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  udrb_pkg::ctrl_cmd_t   cmd_i,
  input  udrb_pkg::in_item_t    in_data_i,
  output udrb_pkg::out_item_t   out_data_o
);
  import udrb_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int CW = PW + 1;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    ptr_next = (p == PW'(BUFFER_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  logic [7:0]    rx_mem_q [BUFFER_DEPTH];
  logic [7:0]    tx_mem_q [BUFFER_DEPTH];
  logic [7:0]    rx_rd_q, tx_rd_q;

  logic [PW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic          rx_dropped_q, rx_dropped_d;
  logic          tx_irq_q, tx_irq_d;
  logic          tx_valid_q, read_valid_q, accepted_q;

  logic          is_service, is_write, is_read;
  logic          rx_full, rx_empty, tx_full, tx_empty;
  logic          rx_push, rx_pop, tx_push, tx_pop;

  logic [CW-1:0]   count;
  logic [CW+7:0]   count_wide;

  assign is_service = cmd_i.exec && (in_data_i.command == CMD_SERVICE);
  assign is_write   = cmd_i.exec && (in_data_i.command == CMD_WRITE);
  assign is_read    = cmd_i.exec && (in_data_i.command == CMD_READ);

  assign rx_full  = (ptr_next(rx_head_q) == rx_tail_q);
  assign rx_empty = (rx_head_q == rx_tail_q);
  assign tx_full  = (ptr_next(tx_head_q) == tx_tail_q);
  assign tx_empty = (tx_head_q == tx_tail_q);

  assign rx_push = is_service && in_data_i.rx_complete && !rx_full;
  assign tx_pop  = is_service && in_data_i.tx_empty && !tx_empty;
  assign tx_push = is_write && !tx_full;
  assign rx_pop  = is_read && !rx_empty;

  always_comb begin
    rx_head_d    = rx_push ? ptr_next(rx_head_q) : rx_head_q;
    rx_tail_d    = rx_pop  ? ptr_next(rx_tail_q) : rx_tail_q;
    tx_head_d    = tx_push ? ptr_next(tx_head_q) : tx_head_q;
    tx_tail_d    = tx_pop  ? ptr_next(tx_tail_q) : tx_tail_q;
    rx_dropped_d = rx_dropped_q
                   || (is_service && in_data_i.rx_complete && rx_full);
    tx_irq_d     = tx_irq_q;
    if (is_service && in_data_i.tx_empty && tx_empty) tx_irq_d = 1'b0;
    if (is_write && in_data_i.batch_last)             tx_irq_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q    <= '0;
      rx_tail_q    <= '0;
      tx_head_q    <= '0;
      tx_tail_q    <= '0;
      rx_dropped_q <= 1'b0;
      tx_irq_q     <= 1'b0;
      tx_valid_q   <= 1'b0;
      read_valid_q <= 1'b0;
      accepted_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      rx_head_q    <= rx_head_d;
      rx_tail_q    <= rx_tail_d;
      tx_head_q    <= tx_head_d;
      tx_tail_q    <= tx_tail_d;
      rx_dropped_q <= rx_dropped_d;
      tx_irq_q     <= tx_irq_d;
      tx_valid_q   <= tx_pop;
      read_valid_q <= rx_pop;
      accepted_q   <= tx_push;
    end
  end

  // Ring storage: one write and one registered read per ring
  always_ff @(posedge clk_i) begin
    if (rx_push) rx_mem_q[rx_head_q] <= in_data_i.data_byte;
    if (cmd_i.exec) rx_rd_q <= rx_mem_q[rx_tail_q];
  end

  always_ff @(posedge clk_i) begin
    if (tx_push) tx_mem_q[tx_head_q] <= in_data_i.data_byte;
    if (cmd_i.exec) tx_rd_q <= tx_mem_q[tx_tail_q];
  end

  // Fill level of the receive ring, saturated to 8 bits
  always_comb begin
    if (rx_head_q >= rx_tail_q) begin
      count = {1'b0, rx_head_q} - {1'b0, rx_tail_q};
    end else begin
      count = {1'b0, rx_head_q} + CW'(BUFFER_DEPTH) - {1'b0, rx_tail_q};
    end
    count_wide = {8'b0, count};
  end

  always_comb begin
    out_data_o.tx_valid       = tx_valid_q;
    out_data_o.tx_byte        = tx_valid_q ? tx_rd_q : 8'h00;
    out_data_o.read_valid     = read_valid_q;
    out_data_o.read_byte      = read_valid_q ? rx_rd_q : 8'h00;
    out_data_o.rx_available   = (count_wide > (CW + 8)'(AvailMax)) ? AvailMax
                                                                   : count_wide[7:0];
    out_data_o.rx_overflow    = rx_dropped_q;
    out_data_o.tx_irq_armed   = tx_irq_q;
    out_data_o.write_accepted = accepted_q;
  end

endmodule

[design/uart_dual_ring_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer
// Receive and transmit byte rings between a serial port and a host.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one command
//   per transfer: port service (store a received byte, pop a byte for the
//   transmitter), host write (queue a transmit byte) or host read (take a
//   received byte). Every command yields exactly one result transfer on
//   out_valid_o / out_ready_i / out_data_o with the status after the step.
//   Each ring holds BUFFER_DEPTH-1 bytes; one slot always stays empty.
// Timing:
//   The result is valid the cycle after the input
//   transfer. Throughput is 1 item per cycle while out_ready_i is high, as
//   the next item is taken in the same cycle the result leaves. Each ring
//   is one memory with one write and one registered read per cycle, which
//   sets that figure.
// Reset:
//   rst_ni clears pointers, the overflow flag and the interrupt enable; ring
//   contents are not cleared (only written slots ever reach the outputs).
// Stall:
//   While a result waits and out_ready_i is low, the result holds and
//   in_ready_o stays low.
// ----------------------------------------------------------------------------
module uart_dual_ring_buffer #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  udrb_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output udrb_pkg::out_item_t  out_data_o
);
  import udrb_pkg::*;

  ctrl_cmd_t cmd;

  // Handshake sequencing
  udrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Rings, pointers and status flags
  udrb_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // Every input transfer produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after input transfer");

  // A pending result blocks new input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  // Overflow flag is sticky
  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_data_o.rx_overflow |=> out_data_o.rx_overflow)
    else $error("overflow flag cleared");

  // At most one byte-moving outcome per result
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.tx_valid, out_data_o.read_valid,
                                out_data_o.write_accepted}) <= 1)
    else $error("conflicting result flags");

endmodule
